/* rtl/core/ssir_pkg.sv */
// Package for the sorted set insert/remove block.
// Holds request and outcome codes, field widths and the cell control struct.
// No dependencies.
package ssir_pkg;

    // Default number of entries in the store.
    localparam int CAPACITY_DEFAULT = 64;

    // Field widths of the stream payloads.
    localparam int VALUE_W   = 32;
    localparam int OUTCOME_W = 3;
    localparam int POS_OUT_W = 7;
    localparam int CNT_OUT_W = 7;

    // Packed stream widths, padded to whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    // Request codes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Outcome codes.
    localparam logic [OUTCOME_W-1:0] OUT_INSERTED = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_PRESENT  = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_REMOVED  = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_NOTFOUND = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_FULL     = 3'd4;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic cmp_en;     // capture the compare flags
        logic do_insert;  // shift up above the insert point
        logic do_remove;  // shift down over the removed entry
    } cell_ctl_t;

endpackage

/* rtl/core/sorted_set_insert_remove_top.sv */
// Sorted set of distinct signed 32-bit integers with insert and remove requests.
// A request is first registered on its transfer on the input; then every cell of the
// chain compares its entry with the value; then the chain shifts and the result is
// formed in the output register. The next request is taken as soon as the chain has
// been updated. The result waits in an output register, so a new request is taken
// while a result is not yet taken; a fresh update stalls only while that register is
// still full. After reset the store is empty at once, with no clearing pass. Depends
// on ssir_pkg, ssir_cell and ssir_pos_enc.
module sorted_set_insert_remove_top
    import ssir_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Requests in.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [0] op, [32:1] value, [39:33] zero
    // Results out.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [2:0] outcome, [9:3] position,
                                            // [16:10] count, [23:17] zero
);

    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0]                state_reg;
    logic [1:0]                state_next;
    logic                      op_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic                      m_tvalid_reg;
    logic [M_TDATA_W-1:0]      m_tdata_reg;
    logic [M_TDATA_W-1:0]      m_tdata_next;

    logic signed [VALUE_W-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]       cell_valid;
    logic [CAPACITY-1:0]       cell_lt;
    logic [CAPACITY-1:0]       cell_eq;
    logic [CW-1:0]             pos;

    cell_ctl_t                 ctl;
    logic                      in_xfer;
    logic                      upd_fire;
    logic                      present;
    logic                      full;
    logic [OUTCOME_W-1:0]      outcome;

    assign in_xfer  = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign upd_fire = (state_reg == ST_UPD) && (!m_tvalid_reg || m_tready);
    assign present  = |cell_eq;
    assign full     = (count_reg == CW'(CAPACITY));

    // Control for the chain.
    always_comb
    begin
        ctl.cmp_en    = (state_reg == ST_CMP);
        ctl.do_insert = upd_fire && (op_reg == OP_INSERT) && !present && !full;
        ctl.do_remove = upd_fire && (op_reg == OP_REMOVE) && present;
    end

    // Chain of cells, each linked to its two neighbors.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [VALUE_W-1:0] below_value;
        logic                      below_valid;
        logic                      below_lt;
        logic signed [VALUE_W-1:0] above_value;
        logic                      above_valid;

        if (i == 0) begin : g_first
            assign below_value = value_reg;
            assign below_valid = 1'b1;
            assign below_lt    = 1'b1;
        end else begin : g_inner_lo
            assign below_value = cell_value[i-1];
            assign below_valid = cell_valid[i-1];
            assign below_lt    = cell_lt[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign above_value = '0;
            assign above_valid = 1'b0;
        end else begin : g_inner_hi
            assign above_value = cell_value[i+1];
            assign above_valid = cell_valid[i+1];
        end

        ssir_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .key         (value_reg),
            .below_value (below_value),
            .below_valid (below_valid),
            .below_lt    (below_lt),
            .above_value (above_value),
            .above_valid (above_valid),
            .value       (cell_value[i]),
            .valid       (cell_valid[i]),
            .lt          (cell_lt[i]),
            .eq          (cell_eq[i])
        );
    end

    ssir_pos_enc #(
        .CAPACITY (CAPACITY),
        .PW       (CW)
    ) u_pos_enc (
        .lt  (cell_lt),
        .pos (pos)
    );

    // Outcome and new count.
    always_comb
    begin
        count_next = count_reg;
        if (op_reg == OP_INSERT) begin
            if (present) begin
                outcome = OUT_PRESENT;
            end else if (full) begin
                outcome = OUT_FULL;
            end else begin
                outcome    = OUT_INSERTED;
                count_next = count_reg + CW'(1);
            end
        end else begin
            if (present) begin
                outcome    = OUT_REMOVED;
                count_next = count_reg - CW'(1);
            end else begin
                outcome = OUT_NOTFOUND;
            end
        end
        m_tdata_next = {
            (M_TDATA_W - OUTCOME_W - POS_OUT_W - CNT_OUT_W)'(0),
            CNT_OUT_W'(count_next),
            POS_OUT_W'(pos),
            outcome
        };
    end

    // Request sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (upd_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (upd_fire) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer) begin
            op_reg    <= s_tdata[0];
            value_reg <= s_tdata[VALUE_W:1];
        end
        if (upd_fire) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* rtl/core/ssir_cell.sv */
// One storage cell of the sorted chain: holds a value and an occupied bit.
// Compares its value with the request and shifts with its neighbors.
// Depends on ssir_pkg.
module ssir_cell
    import ssir_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cell_ctl_t                 ctl,
    input  logic signed [VALUE_W-1:0] key,
    // Neighbor below (lower index).
    input  logic signed [VALUE_W-1:0] below_value,
    input  logic                      below_valid,
    input  logic                      below_lt,
    // Neighbor above (higher index).
    input  logic signed [VALUE_W-1:0] above_value,
    input  logic                      above_valid,
    // Cell state and flags.
    output logic signed [VALUE_W-1:0] value,
    output logic                      valid,
    output logic                      lt,
    output logic                      eq
);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      valid_reg;
    logic                      valid_next;
    logic                      lt_reg;
    logic                      eq_reg;

    // Cells below the insert or remove point keep their entry; the others take the key or a neighbor's entry.
    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctl.do_insert && !lt_reg) begin
            if (below_lt) begin
                value_next = key;
                valid_next = 1'b1;
            end else begin
                value_next = below_value;
                valid_next = below_valid;
            end
        end else if (ctl.do_remove && !lt_reg) begin
            value_next = above_value;
            valid_next = above_valid;
        end
    end

    // Occupied bit and compare flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (ctl.cmp_en) begin
                lt_reg <= valid_reg && (value_reg < key);
                eq_reg <= valid_reg && (value_reg == key);
            end
        end
    end

    // Stored value.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

/* rtl/core/ssir_pos_enc.sv */
// Turns the chain's thermometer of less-than flags into the insert position.
// The position is the index of the first cell whose entry is not less.
// Depends on ssir_pkg.
module ssir_pos_enc
    import ssir_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT,
    parameter int PW       = $clog2(CAPACITY + 1)
)
(
    input  logic [CAPACITY-1:0] lt,
    output logic [PW-1:0]       pos
);

    // Mark the boundary cell and OR its index into the result.
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (!lt[i] && ((i == 0) || lt[(i == 0) ? 0 : i - 1])) begin
                pos = pos | PW'(i);
            end
        end
        if (lt[CAPACITY-1]) begin
            pos = pos | PW'(CAPACITY);
        end
    end

endmodule
